>>> design/rav1dp_pkg.sv
// Shared types and constants for the RTP AV1 payload depacketizer.
// No dependencies; the front end, back end and top level import this package.
package rav1dp_pkg;

  // Parser phase: header wait, LEB128 length field, counted element data,
  // element that runs to the end of the packet.
  typedef enum logic [1:0] {
    PH_HDR  = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_TAIL = 2'd3
  } phase_t;

  // Front-to-back queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Configuration space
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_IDX_DROP_MASK = 1'b0;
  localparam logic [15:0] DROP_MASK_RST = 16'h7F05;

  // Parser widths and limits
  localparam int LBC_W = 4;
  localparam logic [LBC_W-1:0] LBC_MAX = 4'hF;
  localparam logic [1:0] IDX_MAX = 2'd3;
  localparam logic [LBC_W-1:0] LBC_SAT_SHIFT = 4'd5;

  // Classified input byte as it travels through the queue
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       drop_hit;
  } item_t;

endpackage

>>> design/rav1dp_ifs.sv
// Valid/ready channel interfaces for the depacketizer input and result streams.
// No dependencies.
interface rav1dp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       packet_first;
  logic       packet_last;

  modport source (output valid, payload_byte, packet_first, packet_last, input ready);
  modport sink   (input valid, payload_byte, packet_first, packet_last, output ready);
endinterface

interface rav1dp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       obu_end;
  logic       discard_partial;
  logic       length_error;

  modport source (output valid, out_byte, byte_valid, obu_end, discard_partial, length_error,
                  input ready);
  modport sink   (input valid, out_byte, byte_valid, obu_end, discard_partial, length_error,
                  output ready);
endinterface

>>> design/rav1dp_front.sv
// Front end: accept input bytes, tag OBU-type drop hits, queue them for the parser.
// Depends on rav1dp_pkg and rav1dp_in_if.
module rav1dp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [15:0]         drop_type_mask,
  rav1dp_in_if.sink           in_ch,
  input  logic                pop,
  output logic                q_valid,
  output rav1dp_pkg::item_t   q_item
);
  import rav1dp_pkg::*;

  item_t             q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  logic              do_pop;
  item_t             cls;

  // Classify: look up the drop bit for the OBU type field of this byte
  always_comb begin
    cls.data     = in_ch.payload_byte;
    cls.first    = in_ch.packet_first;
    cls.last     = in_ch.packet_last;
    cls.drop_hit = drop_type_mask[in_ch.payload_byte[6:3]];
  end

  assign in_ch.ready = (cnt_r != QCNT_W'(QDEPTH));
  assign push        = in_ch.valid & in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign do_pop      = pop & q_valid;
  assign q_item      = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

>>> design/rav1dp_back.sv
// Back end: aggregation-header / LEB128 / element parser with a registered result stage.
// Depends on rav1dp_pkg and rav1dp_out_if.
module rav1dp_back #(
  parameter int LEB_MAX_BYTES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  rav1dp_pkg::item_t   q_item,
  output logic                pop,
  rav1dp_out_if.source        out_ch
);
  import rav1dp_pkg::*;

  // Parser state
  phase_t           phase_r, phase_nxt;
  logic             z_r, z_nxt;
  logic             y_r, y_nxt;
  logic [1:0]       w_r, w_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic [LBC_W-1:0] lbc_r, lbc_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic             frag_r, frag_nxt;
  logic             drop_r, drop_nxt;
  logic             skip_r, skip_nxt;
  logic             started_r, started_nxt;

  // Result register
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_bv_r, out_bv_nxt;
  logic             out_oe_r, out_oe_nxt;
  logic             out_dp_r, out_dp_nxt;
  logic             out_le_r, out_le_nxt;

  // Byte classification in the current state
  logic [7:0]       b;
  logic             do_hdr, do_len, do_data;
  logic [LBC_W-1:0] lbc_inc;
  logic [4:0]       shamt;
  logic [39:0]      sum;
  logic [31:0]      acc_upd;
  logic             len_done, len_trunc, len_zero, len_go;
  logic             begin_el, cont_el, new_obu;
  logic             skip_eff, drop_eff, stale_dp, frag_b, started_b;
  logic [31:0]      rem_dec;
  logic             elem_last, data_trunc, emit;
  logic [1:0]       idx_inc;
  logic             hdr_trunc;

  function automatic phase_t enter_ph(input logic last, input logic [1:0] w,
                                      input logic [1:0] idx);
    if (last) begin
      return PH_HDR;
    end else if (w != 2'd0 && idx == w - 2'd1) begin
      return PH_TAIL;
    end
    return PH_LEN;
  endfunction

  assign pop = q_valid & (~out_valid_r | out_ch.ready);

  always_comb begin
    b        = q_item.data;
    do_hdr   = q_item.first;
    do_len   = ~q_item.first & (phase_r == PH_LEN);
    do_data  = ~q_item.first & (phase_r == PH_DATA || phase_r == PH_TAIL);
    hdr_trunc = (phase_r != PH_HDR);
    idx_inc  = (idx_r < IDX_MAX) ? idx_r + 2'd1 : idx_r;

    // LEB128 accumulate, saturating at 2^32-1
    lbc_inc = (lbc_r < LBC_MAX) ? lbc_r + 1'b1 : lbc_r;
    case (lbc_r)
      4'd0:    shamt = 5'd0;
      4'd1:    shamt = 5'd7;
      4'd2:    shamt = 5'd14;
      4'd3:    shamt = 5'd21;
      4'd4:    shamt = 5'd28;
      default: shamt = 5'd0;
    endcase
    sum = {8'h00, acc_r} + (40'(b[6:0]) << shamt);
    if (b[6:0] == 7'd0) begin
      acc_upd = acc_r;
    end else if (lbc_r >= LBC_SAT_SHIFT) begin
      acc_upd = '1;
    end else if (sum[39:32] != 8'h00) begin
      acc_upd = '1;
    end else begin
      acc_upd = sum[31:0];
    end
    len_done  = ~b[7] | (lbc_inc >= LBC_W'(LEB_MAX_BYTES));
    len_trunc = q_item.last & (~len_done | (acc_upd != '0));
    len_zero  = len_done & (acc_upd == '0);
    len_go    = len_done & (acc_upd != '0) & ~q_item.last;

    // Element data
    begin_el   = (lbc_r == '0);
    cont_el    = z_r & (idx_r == 2'd0);
    new_obu    = begin_el & ~cont_el;
    skip_eff   = begin_el ? (cont_el & ~frag_r) : skip_r;
    drop_eff   = new_obu ? q_item.drop_hit : drop_r;
    stale_dp   = new_obu & frag_r & started_r;
    frag_b     = frag_r & ~new_obu;
    started_b  = started_r & ~(new_obu & frag_r);
    rem_dec    = (rem_r != '0) ? rem_r - 32'd1 : rem_r;
    elem_last  = (phase_r == PH_DATA) ? (rem_dec == '0) : q_item.last;
    data_trunc = q_item.last & ~elem_last;
    emit       = ~data_trunc & ~skip_eff & ~drop_eff;
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (pop) begin
      if (do_hdr) begin
        phase_nxt = enter_ph(q_item.last, b[5:4], 2'd0);
      end else if (do_len) begin
        if (len_trunc) begin
          phase_nxt = PH_HDR;
        end else if (len_zero) begin
          phase_nxt = enter_ph(q_item.last, w_r, idx_inc);
        end else if (len_go) begin
          phase_nxt = PH_DATA;
        end
      end else if (do_data) begin
        if (data_trunc) begin
          phase_nxt = PH_HDR;
        end else if (elem_last) begin
          phase_nxt = enter_ph(q_item.last, w_r, idx_inc);
        end
      end
    end
  end

  // Datapath state and result
  always_comb begin
    z_nxt         = z_r;
    y_nxt         = y_r;
    w_nxt         = w_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    lbc_nxt       = lbc_r;
    rem_nxt       = rem_r;
    frag_nxt      = frag_r;
    drop_nxt      = drop_r;
    skip_nxt      = skip_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    out_byte_nxt  = out_byte_r;
    out_bv_nxt    = out_bv_r;
    out_oe_nxt    = out_oe_r;
    out_dp_nxt    = out_dp_r;
    out_le_nxt    = out_le_r;

    if (pop) begin
      out_bv_nxt = 1'b0;
      out_oe_nxt = 1'b0;
      out_dp_nxt = 1'b0;
      out_le_nxt = 1'b0;

      if (do_hdr) begin
        // A header inside a packet truncates what was in progress
        out_le_nxt  = hdr_trunc;
        out_dp_nxt  = hdr_trunc & started_r;
        started_nxt = hdr_trunc ? 1'b0 : started_r;
        frag_nxt    = hdr_trunc ? 1'b0 : frag_r;
        drop_nxt    = hdr_trunc ? 1'b0 : drop_r;
        z_nxt       = b[7];
        y_nxt       = b[6];
        w_nxt       = b[5:4];
        idx_nxt     = 2'd0;
        skip_nxt    = 1'b0;
        // No continuation: drop a stale fragment
        if (~b[7] & frag_nxt) begin
          out_dp_nxt  = out_dp_nxt | started_nxt;
          frag_nxt    = 1'b0;
          started_nxt = 1'b0;
          drop_nxt    = 1'b0;
        end
        lbc_nxt = '0;
        acc_nxt = '0;
        rem_nxt = '0;
      end else if (do_len) begin
        acc_nxt = acc_upd;
        lbc_nxt = lbc_inc;
        if (len_trunc) begin
          out_le_nxt  = 1'b1;
          out_dp_nxt  = started_r;
          started_nxt = 1'b0;
          frag_nxt    = 1'b0;
          drop_nxt    = 1'b0;
          skip_nxt    = 1'b0;
        end else if (len_zero) begin
          // Zero-length element: count it and move on
          idx_nxt = idx_inc;
          lbc_nxt = '0;
          acc_nxt = '0;
          rem_nxt = '0;
        end else if (len_go) begin
          rem_nxt = acc_upd;
          lbc_nxt = '0;
        end
      end else if (do_data) begin
        out_dp_nxt  = stale_dp;
        frag_nxt    = frag_b;
        started_nxt = started_b;
        skip_nxt    = skip_eff;
        drop_nxt    = drop_eff;
        lbc_nxt     = LBC_W'(1);
        if (phase_r == PH_DATA) begin
          rem_nxt = rem_dec;
        end
        if (data_trunc) begin
          out_le_nxt  = 1'b1;
          out_dp_nxt  = stale_dp | started_b;
          started_nxt = 1'b0;
          frag_nxt    = 1'b0;
          drop_nxt    = 1'b0;
          skip_nxt    = 1'b0;
        end else begin
          out_bv_nxt  = emit;
          started_nxt = started_b | emit;
          if (elem_last) begin
            if (~skip_eff) begin
              if (y_r & q_item.last) begin
                frag_nxt = 1'b1;
              end else begin
                out_oe_nxt  = emit;
                frag_nxt    = 1'b0;
                started_nxt = 1'b0;
                drop_nxt    = 1'b0;
              end
            end
            skip_nxt = 1'b0;
            idx_nxt  = idx_inc;
            lbc_nxt  = '0;
            acc_nxt  = '0;
            rem_nxt  = '0;
          end
        end
      end

      out_byte_nxt  = out_bv_nxt ? b : 8'h00;
      out_valid_nxt = out_bv_nxt | out_oe_nxt | out_dp_nxt | out_le_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR;
      z_r         <= 1'b0;
      y_r         <= 1'b0;
      w_r         <= 2'd0;
      idx_r       <= 2'd0;
      acc_r       <= '0;
      lbc_r       <= '0;
      rem_r       <= '0;
      frag_r      <= 1'b0;
      drop_r      <= 1'b0;
      skip_r      <= 1'b0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      z_r         <= z_nxt;
      y_r         <= y_nxt;
      w_r         <= w_nxt;
      idx_r       <= idx_nxt;
      acc_r       <= acc_nxt;
      lbc_r       <= lbc_nxt;
      rem_r       <= rem_nxt;
      frag_r      <= frag_nxt;
      drop_r      <= drop_nxt;
      skip_r      <= skip_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_bv_r   <= out_bv_nxt;
    out_oe_r   <= out_oe_nxt;
    out_dp_r   <= out_dp_nxt;
    out_le_r   <= out_le_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.out_byte        = out_byte_r;
  assign out_ch.byte_valid      = out_bv_r;
  assign out_ch.obu_end         = out_oe_r;
  assign out_ch.discard_partial = out_dp_r;
  assign out_ch.length_error    = out_le_r;

`ifndef NO_ASSERTIONS
  a_last_ends_packet: assert property (@(posedge clk) disable iff (!rst_n)
    pop && q_item.last |=> phase_r == PH_HDR)
    else $error("packet end did not return parser to header wait");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_LEN |-> lbc_r < LBC_W'(LEB_MAX_BYTES))
    else $error("length field ran past its byte limit");

  a_data_remaining: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> rem_r != '0)
    else $error("counted element phase with nothing remaining");

  a_end_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_oe_r |-> out_bv_r)
    else $error("OBU end flagged without a data byte");
`endif

endmodule

>>> design/rtp_av1_payload_depacketizer_core.sv
// Top level of the RTP AV1 payload depacketizer: APB register, front end, back end.
// Depends on rav1dp_pkg, rav1dp_ifs, rav1dp_front and rav1dp_back.

// Streams RTP AV1 payload bytes in (packet_first on the aggregation header,
// packet_last on the final byte) and OBU bytes out, one item per cycle
// sustained while the result side keeps up. Each accepted item lands in a
// two-entry queue; the parser takes one item per cycle from the queue and
// registers its result, so a result is presented once its item has passed
// the queue and the result register, and items that cause no result vanish.
// The rate is set by the parser's combinational update, whose longest path
// is the 32-bit LEB128 accumulate-and-saturate. Either side may stall
// independently: the queue absorbs input while the result register waits.
// Only drop_type_mask is writable (byte address 0); write it while the block is idle.
module rtp_av1_payload_depacketizer_core #(
  parameter int LEB_MAX_BYTES = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  rav1dp_in_if.sink                           in_ch,
  rav1dp_out_if.source                        out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rav1dp_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [rav1dp_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [rav1dp_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                pready
);
  import rav1dp_pkg::*;

  logic [15:0] drop_mask_r, drop_mask_nxt;
  logic        reg_hit;
  logic        q_valid;
  logic        pop;
  item_t       q_item;

  // Register decode: index is the word address
  assign pready  = 1'b1;
  assign reg_hit = (paddr[CFG_ADDR_W-1:2] == REG_IDX_DROP_MASK);

  always_comb begin
    drop_mask_nxt = drop_mask_r;
    if (psel && penable && pwrite && pready && reg_hit) begin
      drop_mask_nxt = pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = {{(CFG_DATA_W - 16){1'b0}}, drop_mask_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_mask_r <= DROP_MASK_RST;
    end else begin
      drop_mask_r <= drop_mask_nxt;
    end
  end

  // Accept and classify bytes, queue them
  rav1dp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .drop_type_mask (drop_mask_r),
    .in_ch          (in_ch),
    .pop            (pop),
    .q_valid        (q_valid),
    .q_item         (q_item)
  );

  // Parse headers, lengths and elements; hold the result for the sink
  rav1dp_back #(
    .LEB_MAX_BYTES (LEB_MAX_BYTES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

>>> tb/rav1dp_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the RTP AV1 depacketizer: tracks drop_type_mask writes, predicts
// each accepted payload item and compares the result stream. Uses rav1dp_pkg, rav1dp_ifs.
module rav1dp_checker #(
  parameter int LEB_MAX_BYTES = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  rav1dp_in_if                              in_mon,
  rav1dp_out_if                             out_mon,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic                              pready,
  input  logic [rav1dp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rav1dp_pkg::CFG_DATA_W-1:0] pwdata,
  output int                                fail_count,
  output int                                pending
);
  import rav1dp_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] DROP_MASK_ADDR = CFG_ADDR_W'(4 * REG_IDX_DROP_MASK);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       obu_end;
    logic       discard_partial;
    logic       length_error;
  } obu_result_t;

  obu_result_t expected_results[$];

  // Parser state as the block should hold it
  logic [15:0]      drop_mask;
  phase_t           phase;
  logic             z_cont;
  logic             y_cont;
  logic [1:0]       w_cnt;
  logic [1:0]       elem_idx;
  logic [31:0]      len_acc;
  logic [LBC_W-1:0] len_cnt;
  logic [31:0]      remaining;
  logic             frag_pend;
  logic             obu_drop;
  logic             elem_skip;
  logic             obu_sent;

  task automatic clear_parser();
    drop_mask = DROP_MASK_RST;
    phase     = PH_HDR;
    z_cont    = 1'b0;
    y_cont    = 1'b0;
    w_cnt     = '0;
    elem_idx  = '0;
    len_acc   = '0;
    len_cnt   = '0;
    remaining = '0;
    frag_pend = 1'b0;
    obu_drop  = 1'b0;
    elem_skip = 1'b0;
    obu_sent  = 1'b0;
  endtask

  task automatic next_element(input logic last);
    len_cnt   = '0;
    len_acc   = '0;
    remaining = '0;
    if (last) begin
      phase = PH_HDR;
    end else if (w_cnt != 2'd0 && elem_idx == 2'(w_cnt - 2'd1)) begin
      phase = PH_TAIL;
    end else begin
      phase = PH_LEN;
    end
  endtask

  // Packet ended early: drop the unfinished OBU and any pending fragment
  task automatic cut_packet(inout logic dp, inout logic le);
    le        = 1'b1;
    dp        = dp | obu_sent;
    obu_sent  = 1'b0;
    frag_pend = 1'b0;
    obu_drop  = 1'b0;
    elem_skip = 1'b0;
    phase     = PH_HDR;
  endtask

  task automatic open_element(input logic [7:0] b, inout logic dp);
    if (z_cont && elem_idx == 2'd0) begin
      elem_skip = !frag_pend;
    end else begin
      elem_skip = 1'b0;
      if (frag_pend) begin
        dp        = dp | obu_sent;
        frag_pend = 1'b0;
        obu_sent  = 1'b0;
      end
      obu_drop = drop_mask[b[6:3]];
    end
    len_cnt = 4'd1;
  endtask

  task automatic close_element(input logic last, input logic emitted, inout logic oe);
    if (!elem_skip) begin
      if (y_cont && last) begin
        frag_pend = 1'b1;
      end else begin
        oe        = emitted;
        frag_pend = 1'b0;
        obu_sent  = 1'b0;
        obu_drop  = 1'b0;
      end
    end
    elem_skip = 1'b0;
    if (elem_idx < IDX_MAX) elem_idx++;
    next_element(last);
  endtask

  task automatic parse_payload_byte(input logic [7:0] b, input logic first, input logic last,
                                    output logic hit, output obu_result_t res);
    logic        bv, oe, dp, le, done, elem_last;
    logic [63:0] sum;
    int          shift;
    bv = 1'b0;
    oe = 1'b0;
    dp = 1'b0;
    le = 1'b0;
    if (first) begin
      if (phase != PH_HDR) cut_packet(dp, le);
      z_cont    = b[7];
      y_cont    = b[6];
      w_cnt     = b[5:4];
      elem_idx  = '0;
      elem_skip = 1'b0;
      if (!z_cont && frag_pend) begin
        dp        = dp | obu_sent;
        frag_pend = 1'b0;
        obu_sent  = 1'b0;
        obu_drop  = 1'b0;
      end
      next_element(last);
    end else if (phase == PH_LEN) begin
      shift = 7 * int'(len_cnt);
      if (b[6:0] != 7'd0) begin
        if (shift >= 32) begin
          len_acc = '1;
        end else begin
          sum     = {32'd0, len_acc} + ({57'd0, b[6:0]} << shift);
          len_acc = (sum > 64'hFFFF_FFFF) ? '1 : sum[31:0];
        end
      end
      if (len_cnt < LBC_MAX) len_cnt++;
      done = !b[7] || len_cnt >= LEB_MAX_BYTES;
      if (!done) begin
        if (last) cut_packet(dp, le);
      end else if (len_acc == 32'd0) begin
        // zero-length element: count it and move on
        if (elem_idx < IDX_MAX) elem_idx++;
        next_element(last);
      end else if (last) begin
        cut_packet(dp, le);
      end else begin
        remaining = len_acc;
        len_cnt   = '0;
        phase     = PH_DATA;
      end
    end else if (phase == PH_DATA || phase == PH_TAIL) begin
      if (len_cnt == '0) open_element(b, dp);
      if (phase == PH_DATA) begin
        if (remaining != 32'd0) remaining--;
        elem_last = (remaining == 32'd0);
      end else begin
        elem_last = last;
      end
      if (!elem_last && last) begin
        cut_packet(dp, le);
      end else begin
        if (!elem_skip && !obu_drop) begin
          bv       = 1'b1;
          obu_sent = 1'b1;
        end
        if (elem_last) close_element(last, bv, oe);
      end
    end
    hit = bv | oe | dp | le;
    res = '{out_byte: bv ? b : 8'h00, byte_valid: bv, obu_end: oe,
            discard_partial: dp, length_error: le};
  endtask

  always @(posedge clk) begin : scoreboard
    obu_result_t got, want, pred;
    logic        hit;
    if (!rst_n) begin
      clear_parser();
      expected_results.delete();
      fail_count = 0;
    end else begin
      // Results leave only after their item passes the queue and result register; check them first
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_byte: out_mon.out_byte, byte_valid: out_mon.byte_valid,
                obu_end: out_mon.obu_end, discard_partial: out_mon.discard_partial,
                length_error: out_mon.length_error};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result byte %02h bv %b end %b dp %b le %b", $time,
                     got.out_byte, got.byte_valid, got.obu_end, got.discard_partial,
                     got.length_error);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $write("%0t: result mismatch, expected byte %02h bv %b end %b dp %b le %b,",
                     $time, want.out_byte, want.byte_valid, want.obu_end,
                     want.discard_partial, want.length_error);
              $display(" got byte %02h bv %b end %b dp %b le %b", got.out_byte,
                       got.byte_valid, got.obu_end, got.discard_partial, got.length_error);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        parse_payload_byte(in_mon.payload_byte, in_mon.packet_first, in_mon.packet_last,
                           hit, pred);
        if (hit) expected_results.push_back(pred);
      end
      if (psel && penable && pwrite && pready && paddr == DROP_MASK_ADDR)
        drop_mask = pwdata[15:0];
    end
    pending = expected_results.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Testbench top for rtp_av1_payload_depacketizer_core: clock, reset, payload and
// register stimulus, result-side stalls and the verdict. Uses rav1dp_pkg, rav1dp_ifs, rav1dp_checker.
module tb;
  import rav1dp_pkg::*;

  localparam int LEB_MAX         = 8;
  localparam int NUM_PHASES      = 5;
  localparam int ITEMS_PER_PHASE = 320;
  localparam logic [CFG_ADDR_W-1:0] DROP_MASK_ADDR = CFG_ADDR_W'(4 * REG_IDX_DROP_MASK);

  // One payload item: byte, packet_first, packet_last
  typedef struct packed {
    logic [7:0] b;
    logic       first;
    logic       last;
  } pay_item_t;

  // Directed opening, written as {byte, first, last}:
  // stray byte outside a packet; a fragment left pending by Y; a header with Z
  // clear that discards it, followed by a dropped OBU; a continuation with no
  // fragment (skipped); a zero-length element, then a length field stopped by
  // the byte limit with its continuation bit still set, a one-byte OBU, and a
  // missing packet end; an OBU of type 15 with the top byte value; a dropped
  // element cut short by the packet end.
  localparam pay_item_t DIRECTED [25] = '{
    {8'hFF, 2'b00},
    {8'h50, 2'b10}, {8'h32, 2'b00}, {8'h80, 2'b01},
    {8'h10, 2'b10}, {8'h12, 2'b00}, {8'h00, 2'b01},
    {8'h90, 2'b10}, {8'h44, 2'b01},
    {8'h00, 2'b10}, {8'h00, 2'b00}, {8'h81, 2'b00}, {8'h80, 2'b00}, {8'h80, 2'b00},
    {8'h80, 2'b00}, {8'h80, 2'b00}, {8'h80, 2'b00}, {8'h80, 2'b00}, {8'h80, 2'b00},
    {8'h32, 2'b00},
    {8'h10, 2'b10}, {8'hFF, 2'b01},
    {8'h00, 2'b10}, {8'h03, 2'b00}, {8'h00, 2'b01}
  };

  logic                  clk     = 1'b0;
  logic                  rst_n   = 1'b0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    fails;
  int                    pending;

  // Sender pacing and packet generator state
  int        sent       = 0;
  int        burst_left = 0;
  int        gap_max    = 0;
  bit        frag_open  = 1'b0;
  bit        hold_req   = 1'b0;
  pay_item_t pkt_q[$];

  rav1dp_in_if  in_ch ();
  rav1dp_out_if out_ch ();

  rtp_av1_payload_depacketizer_core #(
    .LEB_MAX_BYTES(LEB_MAX)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  rav1dp_checker #(
    .LEB_MAX_BYTES(LEB_MAX)
  ) chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .fail_count(fails),
    .pending   (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // Hard stop in case the block hangs; far above the slowest legal run
  initial begin
    #2_000_000;
    $display("[rtp_av1_payload_depacketizer_core] ERROR");
    $finish;
  end

  // Result side: stall on a pattern whose mode is redrawn at random when its run ends.
  // A toggle of hold_req starts a long hold-off, counted here, that lets the
  // block fill up and push back on its input.
  initial begin : result_sink
    bit hold_ack;
    int hold_left;
    int rx_mode;
    int rx_left;
    hold_ack     = 1'b0;
    hold_left    = 0;
    rx_mode      = 0;
    rx_left      = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = $urandom_range(60, 120);
        out_ch.ready <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_left = $urandom_range(20, 150);
        end
        rx_left--;
        case (rx_mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= rx_left[1];
        endcase
      end
    end
  end

  // Offer one item and hold it until accepted. Called at a falling edge;
  // returns at the falling edge after acceptance. A gap of random length
  // opens each new burst unless idling is off.
  task automatic send_item(input pay_item_t it);
    if (gap_max != 0) begin
      if (burst_left == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
    in_ch.valid        <= 1'b1;
    in_ch.payload_byte <= it.b;
    in_ch.packet_first <= it.first;
    in_ch.packet_last  <= it.last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    sent++;
  endtask

  // Stop offering, wait for every expected result, then let the parser settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DROP_MASK_ADDR;
    pwdata  <= {16'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] b);
    pkt_q.push_back({b, 2'b00});
  endtask

  // Mostly short elements; a few zero-length ones, a few long ones
  function automatic int pick_len(input bit tail);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8 && !tail) return 0;
    if (r < 85) return $urandom_range(1, 8);
    if (r < 97) return $urandom_range(9, 40);
    return $urandom_range(41, 300);
  endfunction

  // LEB128 length, now and then padded with redundant bytes up to the byte limit;
  // a field at the limit may keep its continuation bit on the last byte
  task automatic add_leb(input int len);
    int              need;
    int              nb;
    longint unsigned v;
    logic [7:0]      c;
    need = (len < 128) ? 1 : ((len < 16384) ? 2 : 3);
    nb   = need + (($urandom_range(0, 9) == 0) ? $urandom_range(0, LEB_MAX - need) : 0);
    v    = longint'(len);
    for (int i = 0; i < nb; i++) begin
      c = 8'((v >> (7 * i)) & 64'h7F);
      if (i < nb - 1 || (nb == LEB_MAX && $urandom_range(0, 1) == 1)) c[7] = 1'b1;
      push_byte(c);
    end
  endtask

  // Build one packet into pkt_q. Well-formed packets follow the fragment chain
  // (Z set when the last packet left a fragment open); a share of them is then
  // broken: cut short, missing its end mark, padded with stray bytes, too long,
  // or replaced by noise.
  task automatic build_packet();
    bit         z, y, tail;
    int         n, w, len, r, k;
    logic [7:0] hdr;
    pkt_q.delete();
    z   = frag_open ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 9) == 0);
    y   = ($urandom_range(0, 2) == 0);
    n   = $urandom_range(1, 4);
    w   = (n <= 3 && $urandom_range(0, 1) == 1) ? n : 0;
    hdr = {z, y, 2'(w), 4'($urandom_range(0, 15))};
    pkt_q.push_back({hdr, 2'b10});
    // Now and then a header-only packet
    if ($urandom_range(0, 24) != 0) begin
      for (int i = 0; i < n; i++) begin
        tail = (w != 0 && i == n - 1);
        len  = pick_len(tail);
        if (!tail) begin
          if ($urandom_range(0, 49) == 0) begin
            // Length field that saturates; the packet ends inside the element
            repeat (LEB_MAX) push_byte(8'hFF);
            repeat (2) push_byte(8'($urandom));
            break;
          end
          add_leb(len);
        end
        repeat (len) push_byte(8'($urandom));
      end
    end
    pkt_q[pkt_q.size() - 1].last = 1'b1;
    frag_open = y;

    r = $urandom_range(0, 99);
    if (r < 8 && pkt_q.size() > 1) begin
      k = $urandom_range(0, pkt_q.size() - 2);
      while (pkt_q.size() > k + 1) void'(pkt_q.pop_back());
      pkt_q[k].last = 1'b1;
      frag_open     = 1'b0;
    end else if (r < 13) begin
      pkt_q[pkt_q.size() - 1].last = 1'b0;
    end else if (r < 16) begin
      pkt_q.delete();
      repeat ($urandom_range(3, 10))
        pkt_q.push_back({8'($urandom), ($urandom_range(0, 5) == 0), ($urandom_range(0, 5) == 0)});
    end else if (r < 19) begin
      repeat ($urandom_range(1, 3)) pkt_q.push_front({8'($urandom), 2'b00});
    end else if (r < 22) begin
      pkt_q[pkt_q.size() - 1].last = 1'b0;
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
      pkt_q[pkt_q.size() - 1].last = 1'b1;
    end
  endtask

  initial begin : stimulus
    int          target;
    bit          paused;
    logic [15:0] mask_val;
    in_ch.valid        = 1'b0;
    in_ch.payload_byte = '0;
    in_ch.packet_first = 1'b0;
    in_ch.packet_last  = 1'b0;
    paused             = 1'b0;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED[i]) send_item(DIRECTED[i]);

    // Phase 0 runs with the reset mask; later phases load all-kept, all-dropped
    // and random masks, each written only once the block has gone quiet.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) begin
        drain();
        case (ph)
          1:       mask_val = 16'h0000;
          2:       mask_val = 16'hFFFF;
          default: mask_val = 16'($urandom_range(0, 65535));
        endcase
        cfg_write(mask_val);
      end
      // Long hold-off on the result side while payload keeps coming
      if (ph == 1) hold_req <= ~hold_req;
      target = sent + ITEMS_PER_PHASE;
      while (sent < target) begin
        // Pause the sender until every result is out, mid-phase
        if (ph == 3 && !paused && sent >= target - ITEMS_PER_PHASE / 2) begin
          drain();
          paused = 1'b1;
        end
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 3))
            0:       gap_max = 0;
            1:       gap_max = 1;
            2:       gap_max = 3;
            default: gap_max = 8;
          endcase
        end
        if ($urandom_range(0, 39) == 0) hold_req <= ~hold_req;
        build_packet();
        foreach (pkt_q[i]) send_item(pkt_q[i]);
      end
    end

    drain();
    if (fails == 0) begin
      $display("[rtp_av1_payload_depacketizer_core] OK");
    end else begin
      $display("[rtp_av1_payload_depacketizer_core] ERROR");
    end
    $finish;
  end

endmodule
